// ===== rtl/tpmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmp_pkg: shared types and constants for the trapezoidal path profiler
// widths of the fixed point fields, command and register codes, result record
// ----------------------------------------------------------------------------
package tpmp_pkg;

  localparam int POS_W      = 32;  // q24.8 distances
  localparam int SPD_W      = 24;  // q16.8 speed and acceleration
  localparam int DT_W       = 16;  // q0.16 seconds
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // shared multiplier operand widths: adist * 2a is the widest product
  localparam int MUL_A_W = POS_W;
  localparam int MUL_B_W = SPD_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int VV_W    = 2 * SPD_W;

  localparam int IN_TDATA_W  = ((DT_W + POS_W + 7) / 8) * 8;
  localparam int RES_W       = POS_W + SPD_W + 2;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic [SPD_W-1:0] ONE_Q8 = SPD_W'(256);

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK       = 2'd0,
    KIND_SET_TARGET = 2'd1,
    KIND_SET_POS    = 2'd2,
    KIND_STOP       = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL     = 3'd0,
    CFG_MAX_SPEED = 3'd1,
    CFG_TOL       = 3'd2,
    CFG_MIN_BRAKE = 3'd3,
    CFG_PATH_LEN  = 3'd4
  } cfg_idx_t;

  // operand pairs of the shared multiplier
  typedef enum logic [1:0] {
    MUL_VV   = 2'd0,  // v * v
    MUL_BRK  = 2'd1,  // adist * 2a
    MUL_DV   = 2'd2,  // a * dt
    MUL_STEP = 2'd3   // v * dt
  } mul_op_t;

  // result record, position in the low bits
  typedef struct packed {
    logic             reached;
    logic             moving;
    logic [SPD_W-1:0] speed;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

// ===== rtl/tpmp_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmp_mul: shared multiplier of the profiler
// selects one operand pair per cycle while en is high and registers the product
// ----------------------------------------------------------------------------
module tpmp_mul (
  input  logic                             clk,
  input  logic                             en,
  input  tpmp_pkg::mul_op_t                op,
  input  logic [tpmp_pkg::SPD_W-1:0]       speed,
  input  logic [tpmp_pkg::POS_W-1:0]       adist,
  input  logic [tpmp_pkg::SPD_W-1:0]       accel,
  input  logic [tpmp_pkg::DT_W-1:0]        dt,
  output logic [tpmp_pkg::PROD_W-1:0]      prod_r
);

  logic [tpmp_pkg::MUL_A_W-1:0] opa;
  logic [tpmp_pkg::MUL_B_W-1:0] opb;

  always_comb begin
    case (op)
      tpmp_pkg::MUL_VV: begin
        opa = tpmp_pkg::MUL_A_W'(speed);
        opb = tpmp_pkg::MUL_B_W'(speed);
      end
      tpmp_pkg::MUL_BRK: begin
        opa = adist;
        opb = {accel, 1'b0};
      end
      tpmp_pkg::MUL_DV: begin
        opa = tpmp_pkg::MUL_A_W'(accel);
        opb = tpmp_pkg::MUL_B_W'(dt);
      end
      tpmp_pkg::MUL_STEP: begin
        opa = tpmp_pkg::MUL_A_W'(speed);
        opb = tpmp_pkg::MUL_B_W'(dt);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= tpmp_pkg::PROD_W'(opa) * tpmp_pkg::PROD_W'(opb);
    end
  end

endmodule

// ===== rtl/tpmp_obuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmp_obuf: result output register
// holds one finished result until the downstream side takes it
// ----------------------------------------------------------------------------
module tpmp_obuf (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  tpmp_pkg::result_t                    data,
  output logic                                 free,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tpmp_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  logic              valid_r, valid_nxt;
  tpmp_pkg::result_t data_r;

  assign free      = !valid_r || out_tready;
  assign valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = tpmp_pkg::OUT_TDATA_W'(data_r);

endmodule

// ===== rtl/trapezoidal_path_motion_profiler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoidal_path_motion_profiler_core: trapezoidal speed profile along a path
// moves a q24.8 position toward a target, one command per request
// ----------------------------------------------------------------------------
// usage
//   in_*  : command requests; in_tuser carries the command kind (tick, set
//           target, set position, stop), in_tdata the time step and distance
//   out_* : exactly one result per command: position, speed, moving, reached
//   cfg_* : register writes (acceleration, max speed, tolerance, min braking
//           distance, path length), only while no command is in flight
// timing
//   out_tvalid rises once the result is loaded from ST_DONE into the output
//   register; set position, stop and a tick while idle or with zero time go
//   through ST_EXEC only; set target and a tick that arrives on the tolerance
//   check add ST_DIST; a tick whose speed falls to zero adds ST_VV, ST_BRK and
//   ST_DV; a tick that steps also passes ST_STEP and ST_POS
//   the block takes one request at a time; in_tready returns the cycle after
//   the result is handed to the output register; a stepping tick makes four
//   passes through the single shared multiplier (v*v, adist*2a, a*dt, v*dt)
//   plus their compare steps
//   braking uses adist*2a <= v*v, which equals adist <= floor(v*v / 2a)
// reset
//   rst_n low clears position, target, speed and the move flag, and loads the
//   register reset values; no result is pending afterward
// stall
//   a result waits in the output register while out_tready is low; a new
//   request is still taken, but its result waits until the register frees up
// ----------------------------------------------------------------------------
module trapezoidal_path_motion_profiler_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tpmp_pkg::IN_TDATA_W-1:0]     in_tdata,   // elapsed_time, distance
  input  logic [tpmp_pkg::KIND_W-1:0]         in_tuser,   // kind
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tpmp_pkg::OUT_TDATA_W-1:0]    out_tdata,  // position, speed, moving,
                                                          // reached, zero pad
  // register write port
  input  logic                                cfg_we,
  input  logic [tpmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpmp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // one-hot sequencer states
  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_EXEC = 9'b000000010,  // decode command, apply set target, set position and stop
    ST_DIST = 9'b000000100,  // distance to target, tolerance check, issue v*v
    ST_VV   = 9'b000001000,  // latch v*v, issue adist*2a
    ST_BRK  = 9'b000010000,  // braking compare, issue a*dt
    ST_DV   = 9'b000100000,  // speed update
    ST_STEP = 9'b001000000,  // issue v*dt with new speed
    ST_POS  = 9'b010000000,  // crossing test and position update
    ST_DONE = 9'b100000000   // hand result to output register
  } state_t;

  localparam int POS_W = tpmp_pkg::POS_W;
  localparam int SPD_W = tpmp_pkg::SPD_W;
  localparam int DT_W  = tpmp_pkg::DT_W;

  // configuration registers
  logic [SPD_W-1:0] acc_r, max_speed_r;
  logic [POS_W-1:0] tol_r, min_brk_r, path_r;

  // sequencer and command
  state_t              state_r, state_nxt;
  tpmp_pkg::kind_t     kind_r;
  logic [DT_W-1:0]     dt_r;
  logic [POS_W-1:0]    din_r;

  // motion state
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    tgt_r, tgt_nxt;
  logic [SPD_W-1:0]    speed_r, speed_nxt;
  logic                active_r, active_nxt;
  logic                reached_r, reached_nxt;

  // tick scratch
  logic [POS_W-1:0]           adist_r, adist_nxt;
  logic                       dir_r, dir_nxt;
  logic [tpmp_pkg::VV_W-1:0]  vv_r, vv_nxt;
  logic                       near_r, near_nxt;

  // datapath
  logic [SPD_W-1:0]               acc_eff;
  logic                           dir_up;
  logic [POS_W-1:0]               adist_c;
  logic [POS_W-1:0]               pos_arrive;
  logic [tpmp_pkg::PROD_W-1:0]    prod_r;
  logic [SPD_W-1:0]               prod_q16;
  logic [SPD_W-1:0]               spd_dec, spd_inc, spd_new;
  logic [SPD_W:0]                 spd_sum;
  logic [POS_W-1:0]               pos_step;
  logic                           mul_en;
  tpmp_pkg::mul_op_t              mul_op;
  logic                           in_fire;
  logic                           obuf_free, obuf_load;
  tpmp_pkg::result_t              result;

  function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] x,
                                                 input logic [POS_W-1:0] lim);
    clamp_pos = (x > lim) ? lim : x;
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= tpmp_pkg::ONE_Q8;
      max_speed_r <= tpmp_pkg::ONE_Q8;
      tol_r       <= '0;
      min_brk_r   <= '0;
      path_r      <= '0;
    end else if (cfg_we) begin
      case (tpmp_pkg::cfg_idx_t'(cfg_index))
        tpmp_pkg::CFG_ACCEL:     acc_r       <= cfg_wdata[SPD_W-1:0];
        tpmp_pkg::CFG_MAX_SPEED: max_speed_r <= cfg_wdata[SPD_W-1:0];
        tpmp_pkg::CFG_TOL:       tol_r       <= cfg_wdata[POS_W-1:0];
        tpmp_pkg::CFG_MIN_BRAKE: min_brk_r   <= cfg_wdata[POS_W-1:0];
        tpmp_pkg::CFG_PATH_LEN:  path_r      <= cfg_wdata[POS_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // zero acceleration behaves as 1.0
  assign acc_eff = (acc_r == '0) ? tpmp_pkg::ONE_Q8 : acc_r;

  // distance to target and the arrival position
  assign dir_up     = tgt_r > pos_r;
  assign adist_c    = dir_up ? (tgt_r - pos_r) : (pos_r - tgt_r);
  assign pos_arrive = clamp_pos(tgt_r, path_r);

  // both a*dt and v*dt are taken as floor(product / 2^16)
  assign prod_q16 = prod_r[DT_W +: SPD_W];

  // speed update: brake saturates at zero, accelerate caps at max speed
  assign spd_dec = (speed_r > prod_q16) ? (speed_r - prod_q16) : '0;
  assign spd_sum = {1'b0, speed_r} + {1'b0, prod_q16};
  assign spd_inc = (spd_sum > {1'b0, max_speed_r}) ? max_speed_r : spd_sum[SPD_W-1:0];
  assign spd_new = near_r ? spd_dec : spd_inc;

  // no step reaches or passes the target here, so the sum stays in range
  assign pos_step = dir_r ? (pos_r + POS_W'(prod_q16)) : (pos_r - POS_W'(prod_q16));

  // shared multiplier issue schedule
  assign mul_en = state_r inside {ST_DIST, ST_VV, ST_BRK, ST_STEP};

  always_comb begin
    case (state_r)
      ST_VV:   mul_op = tpmp_pkg::MUL_BRK;
      ST_BRK:  mul_op = tpmp_pkg::MUL_DV;
      ST_STEP: mul_op = tpmp_pkg::MUL_STEP;
      default: mul_op = tpmp_pkg::MUL_VV;
    endcase
  end

  tpmp_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op     (mul_op),
    .speed  (speed_r),
    .adist  (adist_r),
    .accel  (acc_eff),
    .dt     (dt_r),
    .prod_r (prod_r)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign obuf_load = (state_r == ST_DONE) && obuf_free;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    tgt_nxt     = tgt_r;
    speed_nxt   = speed_r;
    active_nxt  = active_r;
    reached_nxt = reached_r;
    adist_nxt   = adist_r;
    dir_nxt     = dir_r;
    vv_nxt      = vv_r;
    near_nxt    = near_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          reached_nxt = 1'b0;
          state_nxt   = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (kind_r)
          tpmp_pkg::KIND_TICK: begin
            // idle or zero time step: report state as is
            state_nxt = (active_r && (dt_r != '0)) ? ST_DIST : ST_DONE;
          end
          tpmp_pkg::KIND_SET_TARGET: begin
            tgt_nxt   = clamp_pos(din_r, path_r);
            state_nxt = ST_DIST;
          end
          tpmp_pkg::KIND_SET_POS: begin
            pos_nxt   = clamp_pos(din_r, path_r);
            state_nxt = ST_DONE;
          end
          tpmp_pkg::KIND_STOP: begin
            pos_nxt    = clamp_pos(pos_r, path_r);
            speed_nxt  = '0;
            active_nxt = 1'b0;
            state_nxt  = ST_DONE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end

      ST_DIST: begin
        adist_nxt = adist_c;
        dir_nxt   = dir_up;
        if (adist_c <= tol_r) begin
          pos_nxt     = pos_arrive;
          speed_nxt   = '0;
          active_nxt  = 1'b0;
          reached_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else if (kind_r == tpmp_pkg::KIND_SET_TARGET) begin
          active_nxt = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          state_nxt = ST_VV;
        end
      end

      ST_VV: begin
        vv_nxt    = prod_r[tpmp_pkg::VV_W-1:0];
        state_nxt = ST_BRK;
      end

      ST_BRK: begin
        // inside braking distance: min distance, or adist*2a <= v*v
        near_nxt  = (adist_r <= min_brk_r) ||
                    (prod_r <= tpmp_pkg::PROD_W'(vv_r));
        state_nxt = ST_DV;
      end

      ST_DV: begin
        if (spd_new == '0) begin
          pos_nxt     = pos_arrive;
          speed_nxt   = '0;
          active_nxt  = 1'b0;
          reached_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          speed_nxt = spd_new;
          state_nxt = ST_STEP;
        end
      end

      ST_STEP: begin
        state_nxt = ST_POS;
      end

      ST_POS: begin
        // step reaching or crossing the target ends the move
        if (POS_W'(prod_q16) >= adist_r) begin
          pos_nxt     = pos_arrive;
          speed_nxt   = '0;
          active_nxt  = 1'b0;
          reached_nxt = 1'b1;
        end else begin
          pos_nxt = clamp_pos(pos_step, path_r);
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (obuf_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= '0;
      tgt_r     <= '0;
      speed_r   <= '0;
      active_r  <= 1'b0;
      reached_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      tgt_r     <= tgt_nxt;
      speed_r   <= speed_nxt;
      active_r  <= active_nxt;
      reached_r <= reached_nxt;
    end
  end

  // command capture and tick scratch, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= tpmp_pkg::kind_t'(in_tuser);
      dt_r   <= in_tdata[DT_W-1:0];
      din_r  <= in_tdata[DT_W +: POS_W];
    end
    adist_r <= adist_nxt;
    dir_r   <= dir_nxt;
    vv_r    <= vv_nxt;
    near_r  <= near_nxt;
  end

  assign result.reached  = reached_r;
  assign result.moving   = active_r;
  assign result.speed    = speed_r;
  assign result.position = pos_r;

  tpmp_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (obuf_load),
    .data       (result),
    .free       (obuf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // a stopped profiler never keeps a speed
  a_idle_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (speed_r == '0))
    else $error("speed held while no move is active");

  // the position update step is only reached during a live move
  a_pos_only_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POS) |-> active_r)
    else $error("position step without an active move");

  // an arrival result always reports the move as finished
  a_reached_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (obuf_load && reached_r) |-> (!active_r && (speed_r == '0)))
    else $error("arrival reported while still moving");

endmodule
